@@ hw/rtl/lcdseq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdseq_pkg - shared types and constants for the LCD nibble sequencer
// Request and transfer payloads, action codes, wait selects, register
// indexes and the start-up transfer table.
// ----------------------------------------------------------------------------
package lcdseq_pkg;

  // Request codes
  typedef enum logic [1:0] {
    ACT_STARTUP = 2'd0,
    ACT_COMMAND = 2'd1,
    ACT_CHAR    = 2'd2,
    ACT_NUMBER  = 2'd3
  } action_e;

  // Which timing register follows a transfer
  typedef enum logic [2:0] {
    WSEL_STARTUP,
    WSEL_INIT,
    WSEL_BETWEEN,
    WSEL_SHORT,
    WSEL_LONG
  } wait_sel_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_MUL,
    ST_DIV,
    ST_LOAD,
    ST_HI,
    ST_LO
  } state_e;

  // Configuration register indexes
  localparam logic [2:0] CFG_STARTUP_WAIT = 3'd0;
  localparam logic [2:0] CFG_INIT_WAIT    = 3'd1;
  localparam logic [2:0] CFG_BETWEEN_WAIT = 3'd2;
  localparam logic [2:0] CFG_SHORT_WAIT   = 3'd3;
  localparam logic [2:0] CFG_LONG_WAIT    = 3'd4;

  // Register reset values (microseconds)
  localparam logic [15:0] STARTUP_WAIT_RST = 16'd15000;
  localparam logic [15:0] INIT_WAIT_RST    = 16'd4100;
  localparam logic [15:0] BETWEEN_WAIT_RST = 16'd100;
  localparam logic [15:0] SHORT_WAIT_RST   = 16'd40;
  localparam logic [15:0] LONG_WAIT_RST    = 16'd15200;

  // Protocol constants
  localparam logic [3:0]  INIT_LAST_STEP = 4'd14;
  localparam logic [7:0]  CMD_FIRST_LONG = 8'd4;    // commands below this are clear/home
  localparam logic [3:0]  ASCII_DIGIT_HI = 4'h3;    // high nibble of '0'..'9'
  localparam logic [0:0]  CMD_SET_DDRAM  = 1'b1;    // bit 7 of set-address command
  localparam logic [15:0] RECIP_TEN      = 16'd52429; // x/10 = (x*52429) >> 19
  localparam int unsigned RECIP_SHIFT    = 19;

  typedef struct packed {
    action_e     action;
    logic [7:0]  byte_value;
    logic [15:0] number_value;
    logic        move_cursor;
    logic [6:0]  position;
  } lcd_req_t;

  typedef struct packed {
    logic        strobe_res;
    logic        reg_select;
    logic [3:0]  nibble;
    logic [15:0] wait_us;
    logic [2:0]  chars_sent;
    logic        last;
  } lcd_xfer_t;

  typedef struct packed {
    logic       strobe;
    logic [3:0] nibble;
    wait_sel_e  wsel;
  } init_step_t;

  // Start-up table: wait, 3,3,3,2, then bytes 28 08 01 06 0F
  function automatic init_step_t init_step(input logic [3:0] idx);
    init_step_t s;
    unique case (idx)
      4'd0:    s = '{1'b0, 4'h0, WSEL_STARTUP};
      4'd1:    s = '{1'b1, 4'h3, WSEL_INIT};
      4'd2:    s = '{1'b1, 4'h3, WSEL_BETWEEN};
      4'd3:    s = '{1'b1, 4'h3, WSEL_INIT};
      4'd4:    s = '{1'b1, 4'h2, WSEL_INIT};
      4'd5:    s = '{1'b1, 4'h2, WSEL_BETWEEN};
      4'd6:    s = '{1'b1, 4'h8, WSEL_INIT};
      4'd7:    s = '{1'b1, 4'h0, WSEL_BETWEEN};
      4'd8:    s = '{1'b1, 4'h8, WSEL_INIT};
      4'd9:    s = '{1'b1, 4'h0, WSEL_BETWEEN};
      4'd10:   s = '{1'b1, 4'h1, WSEL_INIT};
      4'd11:   s = '{1'b1, 4'h0, WSEL_BETWEEN};
      4'd12:   s = '{1'b1, 4'h6, WSEL_INIT};
      4'd13:   s = '{1'b1, 4'h0, WSEL_BETWEEN};
      4'd14:   s = '{1'b1, 4'hF, WSEL_INIT};
      default: s = '{1'b0, 4'h0, WSEL_INIT};
    endcase
    return s;
  endfunction

endpackage

@@ hw/rtl/char_lcd_nibble_sequencer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer - 4-bit character LCD transfer sequencer
// Turns start-up, command, character and decimal-number requests into a
// run of nibble transfers, each with register select and a following wait.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy stays high
// until the cycle after the final transfer. Transfers come out one per
// cycle on res_o, each marked by xfer_valid_o for exactly one cycle, and
// the receiver must take every one of them: there is no back-pressure.
// Start-up gives 15 transfers, command and character bytes give 2. A number
// first runs the digit extractor, one shared divide-by-ten unit
// (multiply by reciprocal, then a shift-add back-multiply) that goes through
// the ST_MUL and ST_DIV states for each digit position, then ST_LOAD; then
// 2 transfers for the optional cursor command and 2 per printed digit
// follow. Timing registers are written through the cfg port; the user must
// do so only while the block is idle, and the block itself does not enforce it.
module char_lcd_nibble_sequencer #(
  parameter int unsigned NUMBER_DIGITS = 5
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // request channel
  input  logic                  start,
  output logic                  busy,
  input  lcdseq_pkg::lcd_req_t  req_i,
  // configuration writes
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_idx_i,
  input  logic [15:0]           cfg_data_i,
  // transfer channel
  output logic                  xfer_valid_o,
  output lcdseq_pkg::lcd_xfer_t res_o
);

  import lcdseq_pkg::*;

  localparam int unsigned CW = $clog2(NUMBER_DIGITS + 1);
  localparam int unsigned IW = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;
  localparam logic [CW-1:0] LAST_POS = CW'(NUMBER_DIGITS - 1);

  // timing registers
  logic [15:0] startup_wait_q, init_wait_q, between_wait_q, short_wait_q, long_wait_q;

  // control and datapath
  state_e      state_q, state_d;
  action_e     act_q;
  logic        move_q;
  logic [6:0]  pos_q;
  logic [3:0]  step_q;
  logic [7:0]  byte_q;
  logic        rs_q;
  wait_sel_e   lo_sel_q;
  logic [2:0]  chars_q;
  logic [15:0] rem_q;
  logic [31:0] prod_q;
  logic [CW-1:0] pos_cnt_q;   // digit position under extraction
  logic [CW-1:0] cnt_q;       // digits found, then digits left to send
  logic [3:0]  digits_q [NUMBER_DIGITS];

  logic          accept;
  logic [15:0]   quot;
  logic [15:0]   quot_x10;
  logic [3:0]    digit;
  logic [CW-1:0] cnt_m1;
  logic [IW-1:0] rd_idx;
  logic          more_digits;
  init_step_t    init_cur;
  wait_sel_e     wsel;
  logic [15:0]   wait_val;

  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);

  // divide-by-ten unit: quotient from the registered product, remainder digit
  assign quot     = 16'(prod_q[31:RECIP_SHIFT]);
  assign quot_x10 = (quot << 3) + (quot << 1);
  assign digit    = 4'(rem_q - quot_x10);

  assign cnt_m1      = cnt_q - CW'(1);
  assign rd_idx      = cnt_m1[IW-1:0];
  assign more_digits = (act_q == ACT_NUMBER) && (cnt_q != '0);
  assign init_cur    = init_step(step_q);

  // configuration register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      startup_wait_q <= STARTUP_WAIT_RST;
      init_wait_q    <= INIT_WAIT_RST;
      between_wait_q <= BETWEEN_WAIT_RST;
      short_wait_q   <= SHORT_WAIT_RST;
      long_wait_q    <= LONG_WAIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_STARTUP_WAIT: startup_wait_q <= cfg_data_i;
        CFG_INIT_WAIT:    init_wait_q    <= cfg_data_i;
        CFG_BETWEEN_WAIT: between_wait_q <= cfg_data_i;
        CFG_SHORT_WAIT:   short_wait_q   <= cfg_data_i;
        CFG_LONG_WAIT:    long_wait_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (req_i.action)
            ACT_STARTUP:          state_d = ST_INIT;
            ACT_COMMAND, ACT_CHAR: state_d = ST_HI;
            ACT_NUMBER:           state_d = ST_MUL;
            default:              state_d = ST_IDLE;
          endcase
        end
      end
      ST_INIT: if (step_q == INIT_LAST_STEP) state_d = ST_IDLE;
      ST_MUL:  state_d = ST_DIV;
      ST_DIV:  state_d = (pos_cnt_q == LAST_POS) ? ST_LOAD : ST_MUL;
      ST_LOAD: state_d = ST_HI;
      ST_HI:   state_d = ST_LO;
      ST_LO:   state_d = more_digits ? ST_HI : ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          act_q    <= req_i.action;
          move_q   <= req_i.move_cursor;
          pos_q    <= req_i.position;
          byte_q   <= req_i.byte_value;
          rs_q     <= (req_i.action == ACT_CHAR);
          lo_sel_q <= (req_i.action == ACT_COMMAND && req_i.byte_value < CMD_FIRST_LONG)
                      ? WSEL_LONG : WSEL_SHORT;
          chars_q  <= (req_i.action == ACT_CHAR) ? 3'd1 : 3'd0;
          step_q   <= '0;
          rem_q    <= req_i.number_value;
          pos_cnt_q <= '0;
          cnt_q    <= '0;
        end
      end
      ST_INIT: step_q <= step_q + 4'd1;
      ST_MUL:  prod_q <= rem_q * RECIP_TEN;
      ST_DIV: begin
        digits_q[pos_cnt_q[IW-1:0]] <= digit;
        // digit of this position is printed if the value reaches its weight
        if (pos_cnt_q == '0 || rem_q != '0) cnt_q <= pos_cnt_q + CW'(1);
        rem_q     <= quot;
        pos_cnt_q <= pos_cnt_q + CW'(1);
      end
      ST_LOAD: begin
        chars_q  <= 3'(cnt_q);
        lo_sel_q <= WSEL_SHORT;
        if (move_q) begin
          byte_q <= {CMD_SET_DDRAM, pos_q};
          rs_q   <= 1'b0;
        end else begin
          byte_q <= {ASCII_DIGIT_HI, digits_q[rd_idx]};
          rs_q   <= 1'b1;
          cnt_q  <= cnt_m1;
        end
      end
      ST_LO: begin
        if (more_digits) begin
          byte_q <= {ASCII_DIGIT_HI, digits_q[rd_idx]};
          rs_q   <= 1'b1;
          cnt_q  <= cnt_m1;
        end
      end
      default: ;
    endcase
  end

  // wait register select
  always_comb begin
    case (wsel)
      WSEL_STARTUP: wait_val = startup_wait_q;
      WSEL_INIT:    wait_val = init_wait_q;
      WSEL_BETWEEN: wait_val = between_wait_q;
      WSEL_SHORT:   wait_val = short_wait_q;
      WSEL_LONG:    wait_val = long_wait_q;
      default:      wait_val = short_wait_q;
    endcase
  end

  // transfer outputs
  always_comb begin
    xfer_valid_o     = 1'b0;
    res_o            = '0;
    wsel             = WSEL_BETWEEN;
    unique case (state_q)
      ST_INIT: begin
        xfer_valid_o     = 1'b1;
        wsel             = init_cur.wsel;
        res_o.strobe_res = init_cur.strobe;
        res_o.nibble     = init_cur.nibble;
        res_o.last       = (step_q == INIT_LAST_STEP);
      end
      ST_HI: begin
        xfer_valid_o     = 1'b1;
        wsel             = WSEL_BETWEEN;
        res_o.strobe_res = 1'b1;
        res_o.reg_select = rs_q;
        res_o.nibble     = byte_q[7:4];
      end
      ST_LO: begin
        xfer_valid_o     = 1'b1;
        wsel             = lo_sel_q;
        res_o.strobe_res = 1'b1;
        res_o.reg_select = rs_q;
        res_o.nibble     = byte_q[3:0];
        res_o.last       = !more_digits;
        res_o.chars_sent = more_digits ? 3'd0 : chars_q;
      end
      default: ;
    endcase
    res_o.wait_us = xfer_valid_o ? wait_val : 16'd0;
  end

endmodule
